FILE: rtl/mke_pkg.sv
// shared types, constants and profile tables for the musical key estimator
// no dependencies
package mke_pkg;

    localparam int WEIGHT_BITS = 32;
    localparam int NUM_CLASSES = 12;
    localparam int CLASS_W     = 4;
    localparam int PITCH_W     = 15;
    localparam int LEN_W       = 16;
    localparam int CORR_W      = 16;
    localparam int HIST_BITS   = 14;
    localparam int SUM_W       = WEIGHT_BITS + 4;
    localparam int SHIFT_W     = $clog2(SUM_W);
    localparam int X_W         = HIST_BITS + 5;
    localparam int SXX_W       = 2 * X_W;
    localparam int Y_W         = 14;
    localparam int SXY_W       = X_W + Y_W + 4;
    localparam int SYY_W       = 26;
    localparam int D_W         = 64;
    localparam int DEN_W       = D_W / 2;
    localparam int DIV_STEPS   = 31;
    localparam int R30_W       = 32;
    localparam int CNT_W       = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam int PROF_MAJOR [NUM_CLASSES] =
        '{635, 223, 348, 233, 438, 409, 252, 519, 239, 366, 229, 288};
    localparam int PROF_MINOR [NUM_CLASSES] =
        '{633, 268, 352, 538, 260, 353, 254, 475, 398, 269, 334, 317};

    typedef struct packed {
        logic [CLASS_W-1:0] pclass;
        logic [LEN_W-1:0]   len;
        logic               last;
    } note_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SUM,
        ST_SHIFT,
        ST_HIST,
        ST_SXX,
        ST_DMUL,
        ST_SQRT,
        ST_SXY,
        ST_DIV,
        ST_CMP,
        ST_EMIT
    } back_state_t;

    function automatic int profile_at(input logic minor, input int idx);
        int v;
        v = minor ? PROF_MINOR[idx] : PROF_MAJOR[idx];
        return v;
    endfunction

    function automatic int profile_sum(input logic minor);
        int s;
        s = 0;
        for (int i = 0; i < NUM_CLASSES; i++)
            s += profile_at(minor, i);
        return s;
    endfunction

    // centred profile, scaled by the class count
    function automatic logic signed [Y_W-1:0] profile_y(input logic minor,
                                                        input logic [CLASS_W-1:0] idx);
        int v;
        v = 0;
        if (int'(idx) < NUM_CLASSES)
            v = 12 * profile_at(minor, int'(idx)) - profile_sum(minor);
        return Y_W'(v);
    endfunction

    function automatic longint profile_syy(input logic minor);
        longint s;
        longint y;
        s = 0;
        for (int i = 0; i < NUM_CLASSES; i++) begin
            y = longint'(12 * profile_at(minor, i) - profile_sum(minor));
            s += y * y;
        end
        return s;
    endfunction

    localparam logic [SYY_W-1:0] SYY_MAJOR = SYY_W'(profile_syy(1'b0));
    localparam logic [SYY_W-1:0] SYY_MINOR = SYY_W'(profile_syy(1'b1));

endpackage

FILE: rtl/musical_key_estimator.sv
// top level of the musical key estimator
// depends on mke_pkg, mke_front, mke_queue, mke_back
//
// notes enter one per cycle while busy is low: start with the note fields is
// taken at the clock edge where busy is low. the front end rounds the pitch
// to a semitone and reduces it to a pitch class, and a two-entry queue holds
// classified notes until the back end adds each one to its class weight and
// the total, one note per cycle while the back end is idle, so notes keep a
// sustained rate of one per cycle outside a key evaluation and busy rises
// only when the queue is full. a note marked last starts the key evaluation:
// a sweep for the weight sum, a normalizing shift, two sweeps for the
// histogram and its variance, a shift-add multiply and square root per mode,
// then for each of the 24 candidate keys a dot product, a restoring divider
// and a compare. two more notes of the next set can be queued during that
// time. the result shows for exactly one cycle with done high and cannot be
// held off. a set with zero total weight gives key_valid low and zero fields
module musical_key_estimator
    import mke_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [PITCH_W-1:0]       note_pitch_q8,
    input  logic [LEN_W-1:0]         note_length,
    input  logic                     is_last,
    output logic                     done,
    output logic                     key_valid,
    output logic [CLASS_W-1:0]       key_root,
    output logic                     key_minor,
    output logic signed [CORR_W-1:0] key_correlation
);

    // classified notes between front and back
    logic  push;
    note_t push_item;
    logic  pop;
    note_t head;
    logic  full;
    logic  empty;

    assign busy = full;

    mke_front u_front (
        .start         (start),
        .full          (full),
        .note_pitch_q8 (note_pitch_q8),
        .note_length   (note_length),
        .is_last       (is_last),
        .push          (push),
        .push_item     (push_item)
    );

    mke_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    // accumulation and the iterative correlation search
    mke_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .empty           (empty),
        .pop             (pop),
        .done            (done),
        .key_valid       (key_valid),
        .key_root        (key_root),
        .key_minor       (key_minor),
        .key_correlation (key_correlation)
    );

endmodule

FILE: rtl/mke_queue.sv
// short item queue between front and back
// depends on mke_pkg
module mke_queue
    import mke_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  note_t push_item,
    input  logic  pop,
    output note_t head,
    output logic  full,
    output logic  empty
);

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    note_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    assign full  = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

FILE: rtl/mke_front.sv
// front end: accepts notes and reduces the pitch to a pitch class
// depends on mke_pkg
module mke_front
    import mke_pkg::*;
(
    input  logic               start,
    input  logic               full,
    input  logic [PITCH_W-1:0] note_pitch_q8,
    input  logic [LEN_W-1:0]   note_length,
    input  logic               is_last,
    output logic               push,
    output note_t              push_item
);

    logic [15:0] rounded;
    logic [7:0]  semi;
    logic [13:0] recip;
    logic [7:0]  quot;
    logic [7:0]  rem;
    logic [7:0]  rem_fix;

    always_comb
    begin
        rounded = {1'b0, note_pitch_q8} + 16'd128;
        semi    = rounded[15:8];
        // divide by 12 through multiply by 43/512, then one correction
        recip   = 14'(semi) * 14'd43;
        quot    = 8'(recip >> 9);
        rem     = semi - 8'(quot * 8'd12);
        rem_fix = (rem >= 8'd12) ? rem - 8'd12 : rem;

        push             = start && !full;
        push_item.pclass = rem_fix[CLASS_W-1:0];
        push_item.len    = note_length;
        push_item.last   = is_last;
    end

endmodule

FILE: rtl/mke_back.sv
// back end: weight accumulation and iterative key correlation
// depends on mke_pkg
module mke_back
    import mke_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  note_t                    head,
    input  logic                     empty,
    output logic                     pop,
    output logic                     done,
    output logic                     key_valid,
    output logic [CLASS_W-1:0]       key_root,
    output logic                     key_minor,
    output logic signed [CORR_W-1:0] key_correlation
);

    back_state_t state_reg, state_next;

    logic [WEIGHT_BITS-1:0]  weight_reg [NUM_CLASSES];
    logic [WEIGHT_BITS-1:0]  total_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [SHIFT_W-1:0]      shift_reg;
    logic [HIST_BITS-1:0]    hist_reg [NUM_CLASSES];
    logic [HIST_BITS-1:0]    t_reg;
    logic signed [X_W-1:0]   x_reg [NUM_CLASSES];
    logic [SXX_W-1:0]        sxx_reg;
    logic                    mode_reg;
    logic [CLASS_W-1:0]      root_reg;
    logic [D_W-1:0]          d_acc_reg;
    logic [D_W-1:0]          d_mcand_reg;
    logic [D_W-1:0]          sq_rem_reg;
    logic [D_W-1:0]          sq_res_reg;
    logic [D_W-1:0]          sq_bit_reg;
    logic [DEN_W-1:0]        den_reg [2];
    logic signed [SXY_W-1:0] sxy_reg;
    logic                    neg_reg;
    logic [DEN_W:0]          div_r_reg;
    logic [DIV_STEPS-1:0]    q_reg;
    logic signed [R30_W-1:0] best_reg;
    logic [CLASS_W-1:0]      best_root_reg;
    logic                    best_minor_reg;
    logic                    done_reg;
    logic                    valid_reg;
    logic [CLASS_W-1:0]      root_out_reg;
    logic                    minor_out_reg;
    logic signed [CORR_W-1:0] corr_reg;

    logic [CLASS_W-1:0]      idx;
    logic [WEIGHT_BITS-1:0]  w_rd;
    logic [WEIGHT_BITS:0]    w_sum;
    logic [WEIGHT_BITS:0]    t_sum;
    logic [WEIGHT_BITS-1:0]  w_shift;
    logic [X_W-1:0]          x12;
    logic signed [X_W-1:0]   xv;
    logic signed [SXX_W-1:0] xsq;
    logic [SYY_W-1:0]        syy;
    logic [D_W-1:0]          d_sum;
    logic [D_W-1:0]          sq_try;
    logic                    sq_ge;
    logic [D_W-1:0]          sq_res_next;
    logic [CLASS_W-1:0]      y_idx;
    logic signed [Y_W-1:0]   yv;
    logic signed [SXY_W-1:0] sxy_next;
    logic [SXY_W-1:0]        sxy_abs;
    logic [DEN_W-1:0]        den;
    logic [DEN_W:0]          div_t;
    logic                    div_ge;
    logic signed [R30_W-1:0] r30;
    logic [R30_W-1:0]        best_abs;
    logic [R30_W-1:0]        rounded;
    logic [CORR_W-1:0]       mag14;
    logic                    last_cnt;

    always_comb
    begin
        idx      = (state_reg == ST_IDLE) ? head.pclass : cnt_reg[CLASS_W-1:0];
        w_rd     = weight_reg[idx];
        w_sum    = {1'b0, w_rd} + (WEIGHT_BITS+1)'(head.len);
        t_sum    = {1'b0, total_reg} + (WEIGHT_BITS+1)'(head.len);
        w_shift  = w_rd >> shift_reg;
        last_cnt = (cnt_reg == CNT_W'(NUM_CLASSES - 1));

        x12 = X_W'(hist_reg[idx]) * X_W'(12);
        xv  = $signed(x12) - $signed(X_W'(t_reg));
        xsq = SXX_W'(xv) * SXX_W'(xv);

        syy   = mode_reg ? SYY_MINOR : SYY_MAJOR;
        d_sum = d_acc_reg + (syy[cnt_reg] ? d_mcand_reg : '0);

        sq_try      = sq_res_reg + sq_bit_reg;
        sq_ge       = (sq_rem_reg >= sq_try);
        sq_res_next = sq_ge ? (sq_res_reg >> 1) + sq_bit_reg : sq_res_reg >> 1;

        // profile index rotated by the candidate root
        y_idx    = (idx >= root_reg) ? idx - root_reg
                                     : idx + CLASS_W'(NUM_CLASSES) - root_reg;
        yv       = profile_y(mode_reg, y_idx);
        sxy_next = sxy_reg + SXY_W'(x_reg[idx] * yv);
        sxy_abs  = sxy_next[SXY_W-1] ? SXY_W'(-sxy_next) : SXY_W'(sxy_next);

        den    = den_reg[mode_reg];
        div_t  = (cnt_reg == '0) ? div_r_reg : {div_r_reg[DEN_W-1:0], 1'b0};
        div_ge = (den != '0) && (div_t >= {1'b0, den});

        r30 = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});

        best_abs = best_reg[R30_W-1] ? R30_W'(-best_reg) : R30_W'(best_reg);
        rounded  = best_abs + (R30_W'(1) << 15);
        mag14    = CORR_W'(rounded >> 16);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (!empty && head.last)
                    state_next = ST_CHECK;
            ST_CHECK:
                state_next = (total_reg == '0) ? ST_IDLE : ST_SUM;
            ST_SUM:
                if (last_cnt)
                    state_next = ST_SHIFT;
            ST_SHIFT:
                if (sum_reg[SUM_W-1:HIST_BITS] == '0)
                    state_next = ST_HIST;
            ST_HIST:
                if (last_cnt)
                    state_next = ST_SXX;
            ST_SXX:
                if (last_cnt)
                    state_next = ST_DMUL;
            ST_DMUL:
                if (cnt_reg == CNT_W'(SYY_W - 1))
                    state_next = ST_SQRT;
            ST_SQRT:
                if (cnt_reg == CNT_W'(DEN_W - 1))
                    state_next = mode_reg ? ST_SXY : ST_DMUL;
            ST_SXY:
                if (last_cnt)
                    state_next = ST_DIV;
            ST_DIV:
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = ST_CMP;
            ST_CMP:
                if (mode_reg && root_reg == CLASS_W'(NUM_CLASSES - 1))
                    state_next = ST_EMIT;
                else
                    state_next = ST_SXY;
            ST_EMIT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        pop             = (state_reg == ST_IDLE) && !empty;
        done            = done_reg;
        key_valid       = valid_reg;
        key_root        = root_out_reg;
        key_minor       = minor_out_reg;
        key_correlation = corr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            total_reg <= '0;
            for (int i = 0; i < NUM_CLASSES; i++)
                weight_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            if (pop)
            begin
                weight_reg[idx] <= w_sum[WEIGHT_BITS] ? '1 : w_sum[WEIGHT_BITS-1:0];
                total_reg       <= t_sum[WEIGHT_BITS] ? '1 : t_sum[WEIGHT_BITS-1:0];
            end
            if ((state_reg == ST_CHECK && total_reg == '0) || state_reg == ST_EMIT)
            begin
                done_reg  <= 1'b1;
                total_reg <= '0;
                for (int i = 0; i < NUM_CLASSES; i++)
                    weight_reg[i] <= '0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_CHECK:
            begin
                cnt_reg   <= '0;
                sum_reg   <= '0;
                shift_reg <= '0;
                valid_reg     <= 1'b0;
                root_out_reg  <= '0;
                minor_out_reg <= 1'b0;
                corr_reg      <= '0;
            end
            ST_SUM:
            begin
                sum_reg <= sum_reg + SUM_W'(w_rd);
                cnt_reg <= last_cnt ? '0 : cnt_reg + 1'b1;
                t_reg   <= '0;
            end
            ST_SHIFT:
                if (sum_reg[SUM_W-1:HIST_BITS] != '0)
                begin
                    sum_reg   <= sum_reg >> 1;
                    shift_reg <= shift_reg + 1'b1;
                end
            ST_HIST:
            begin
                hist_reg[idx] <= w_shift[HIST_BITS-1:0];
                t_reg         <= t_reg + w_shift[HIST_BITS-1:0];
                cnt_reg       <= last_cnt ? '0 : cnt_reg + 1'b1;
                sxx_reg       <= '0;
            end
            ST_SXX:
            begin
                x_reg[idx] <= xv;
                sxx_reg    <= sxx_reg + SXX_W'(xsq);
                cnt_reg    <= last_cnt ? '0 : cnt_reg + 1'b1;
                mode_reg    <= 1'b0;
                d_acc_reg   <= '0;
                d_mcand_reg <= D_W'(sxx_reg + SXX_W'(xsq));
            end
            ST_DMUL:
            begin
                // shift-add product of sxx and the profile sum of squares
                d_acc_reg   <= d_sum;
                d_mcand_reg <= d_mcand_reg << 1;
                if (cnt_reg == CNT_W'(SYY_W - 1))
                begin
                    cnt_reg    <= '0;
                    sq_rem_reg <= d_sum;
                    sq_res_reg <= '0;
                    sq_bit_reg <= D_W'(1) << (D_W - 2);
                end
                else
                    cnt_reg <= cnt_reg + 1'b1;
            end
            ST_SQRT:
            begin
                // integer square root, two bits a step
                if (sq_ge)
                    sq_rem_reg <= sq_rem_reg - sq_try;
                sq_res_reg <= sq_res_next;
                sq_bit_reg <= sq_bit_reg >> 2;
                if (cnt_reg == CNT_W'(DEN_W - 1))
                begin
                    den_reg[mode_reg] <= sq_res_next[DEN_W-1:0];
                    cnt_reg     <= '0;
                    mode_reg    <= ~mode_reg;
                    d_acc_reg   <= '0;
                    d_mcand_reg <= D_W'(sxx_reg);
                    root_reg    <= '0;
                    sxy_reg     <= '0;
                end
                else
                    cnt_reg <= cnt_reg + 1'b1;
            end
            ST_SXY:
            begin
                sxy_reg <= sxy_next;
                if (last_cnt)
                begin
                    cnt_reg   <= '0;
                    neg_reg   <= sxy_next[SXY_W-1];
                    div_r_reg <= sxy_abs[DEN_W:0];
                    q_reg     <= '0;
                end
                else
                    cnt_reg <= cnt_reg + 1'b1;
            end
            ST_DIV:
            begin
                // restoring division, one quotient bit a step
                div_r_reg <= div_ge ? div_t - {1'b0, den} : div_t;
                q_reg     <= {q_reg[DIV_STEPS-2:0], div_ge};
                cnt_reg   <= (cnt_reg == CNT_W'(DIV_STEPS - 1)) ? '0 : cnt_reg + 1'b1;
            end
            ST_CMP:
            begin
                // first candidate always taken, later ones only if strictly better
                if ((root_reg == '0 && !mode_reg) || r30 > best_reg)
                begin
                    best_reg       <= r30;
                    best_root_reg  <= root_reg;
                    best_minor_reg <= mode_reg;
                end
                sxy_reg  <= '0;
                mode_reg <= ~mode_reg;
                if (mode_reg)
                    root_reg <= root_reg + 1'b1;
            end
            ST_EMIT:
            begin
                valid_reg     <= 1'b1;
                root_out_reg  <= best_root_reg;
                minor_out_reg <= best_minor_reg;
                corr_reg      <= best_reg[R30_W-1] ? -$signed(mag14) : $signed(mag14);
            end
            default:
            begin
                cnt_reg <= '0;
            end
        endcase
    end

endmodule

FILE: tb/sv/musical_key_estimator_checker.sv
// checker for the musical key estimator: watches the note and key channels,
// predicts each key from the accepted notes and compares it field by field
// depends on mke_pkg for widths and the major and minor profile tables
module musical_key_estimator_checker
    import mke_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic [PITCH_W-1:0]       note_pitch_q8,
    input  logic [LEN_W-1:0]         note_length,
    input  logic                     is_last,
    input  logic                     done,
    input  logic                     key_valid,
    input  logic [CLASS_W-1:0]       key_root,
    input  logic                     key_minor,
    input  logic signed [CORR_W-1:0] key_correlation,
    output int                       mismatches,
    output int                       awaiting
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bit                valid;
        bit [CLASS_W-1:0]  root;
        bit                minor;
        bit [CORR_W-1:0]   corr;
    } key_guess_t;

    localparam bit [63:0] WEIGHT_SAT = (64'd1 << WEIGHT_BITS) - 64'd1;

    bit [63:0]  class_sum [NUM_CLASSES];
    bit [63:0]  total_sum;
    key_guess_t expected_keys [$];

    assign awaiting = expected_keys.size();

    function automatic bit [63:0] sat_add(input bit [63:0] a, input bit [63:0] b);
        bit [63:0] s;
        s = a + b;
        return (s > WEIGHT_SAT) ? WEIGHT_SAT : s;
    endfunction

    function automatic int profile_val(input int mode, input int idx);
        return mode ? PROF_MINOR[idx] : PROF_MAJOR[idx];
    endfunction

    // pearson score of the histogram against all 24 rotated profiles
    function automatic key_guess_t estimate_key();
        key_guess_t g;
        bit [63:0]  sum, sxx, syy, v, res, bitv, den, a, m, mag;
        longint     x [NUM_CLASSES];
        longint     t, sxy, y, r, best, psum;
        int         s;
        bit         have;
        g = '{valid: 0, root: 0, minor: 0, corr: 0};
        if (total_sum == 0)
            return g;
        sum = 0;
        for (int i = 0; i < NUM_CLASSES; i++)
            sum += class_sum[i];
        s = 0;
        while ((sum >> s) >= (64'd1 << HIST_BITS))
            s++;
        t = 0;
        for (int i = 0; i < NUM_CLASSES; i++) begin
            x[i] = longint'(class_sum[i] >> s);
            t += x[i];
        end
        sxx = 0;
        for (int i = 0; i < NUM_CLASSES; i++) begin
            x[i] = 12 * x[i] - t;
            sxx += 64'(x[i] * x[i]);
        end
        have = 0;
        best = 0;
        for (int root = 0; root < NUM_CLASSES; root++) begin
            for (int mode = 0; mode < 2; mode++) begin
                psum = 0;
                for (int i = 0; i < NUM_CLASSES; i++)
                    psum += profile_val(mode, i);
                sxy = 0;
                syy = 0;
                for (int i = 0; i < NUM_CLASSES; i++) begin
                    y = 12 * profile_val(mode, (i + NUM_CLASSES - root) % NUM_CLASSES) - psum;
                    sxy += x[i] * y;
                    syy += 64'(y * y);
                end
                r = 0;
                if (sxx != 0) begin
                    // bitwise integer square root of sxx * syy
                    v = sxx * syy;
                    res = 0;
                    bitv = 64'd1 << 62;
                    while (bitv > v)
                        bitv >>= 2;
                    while (bitv != 0) begin
                        if (v >= res + bitv) begin
                            v -= res + bitv;
                            res = (res >> 1) + bitv;
                        end else
                            res >>= 1;
                        bitv >>= 2;
                    end
                    den = res;
                    if (den != 0) begin
                        a = (sxy < 0) ? 64'(-sxy) : 64'(sxy);
                        m = (a << 30) / den;
                        if (m > (64'd1 << 30))
                            m = 64'd1 << 30;
                        r = (sxy < 0) ? -longint'(m) : longint'(m);
                    end
                end
                if (!have || r > best) begin
                    have = 1;
                    best = r;
                    g.root = CLASS_W'(root);
                    g.minor = 1'(mode);
                end
            end
        end
        // round half away from zero down to q2.14
        mag = ((best < 0) ? 64'(-best) : 64'(best)) + (64'd1 << 15);
        mag >>= 16;
        g.corr = CORR_W'((best < 0) ? -longint'(mag) : longint'(mag));
        g.valid = 1;
        return g;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        key_guess_t exp_key;
        bit [CLASS_W-1:0] pc;
        if (!rst_n) begin
            for (int i = 0; i < NUM_CLASSES; i++)
                class_sum[i] = 0;
            total_sum = 0;
            mismatches = 0;
        end else begin
            if (done) begin
                if (expected_keys.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%t: key result with none expected:", $realtime,
                                 " valid %0d root %0d minor %0d corr %0d",
                                 key_valid, key_root, key_minor, key_correlation);
                end else begin
                    exp_key = expected_keys.pop_front();
                    if (key_valid !== exp_key.valid || key_root !== exp_key.root ||
                        key_minor !== exp_key.minor || key_correlation !== exp_key.corr) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%t: key mismatch: expected valid %0d root %0d",
                                     $realtime, exp_key.valid, exp_key.root,
                                     " minor %0d corr %0d,", exp_key.minor,
                                     $signed(exp_key.corr),
                                     " got valid %0d root %0d minor %0d corr %0d",
                                     key_valid, key_root, key_minor, key_correlation);
                    end
                end
            end
            if (start && !busy) begin
                pc = CLASS_W'(((32'(note_pitch_q8) + 32'd128) >> 8) % NUM_CLASSES);
                class_sum[pc] = sat_add(class_sum[pc], 64'(note_length));
                total_sum = sat_add(total_sum, 64'(note_length));
                if (is_last) begin
                    expected_keys = {expected_keys, estimate_key()};
                    for (int i = 0; i < NUM_CLASSES; i++)
                        class_sum[i] = 0;
                    total_sum = 0;
                end
            end
        end
    end

endmodule

FILE: tb/sv/musical_key_estimator_tb.sv
// testbench top for the musical key estimator: clock, reset, note stimulus
// and the final verdict; checking is done in musical_key_estimator_checker
// depends on mke_pkg, musical_key_estimator and musical_key_estimator_checker
module musical_key_estimator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mke_pkg::*;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [PITCH_W-1:0]       note_pitch_q8;
    logic [LEN_W-1:0]         note_length;
    logic                     is_last;
    logic                     done;
    logic                     key_valid;
    logic [CLASS_W-1:0]       key_root;
    logic                     key_minor;
    logic signed [CORR_W-1:0] key_correlation;
    int                       mismatches;
    int                       awaiting;
    int                       notes_sent;

    musical_key_estimator dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .note_pitch_q8   (note_pitch_q8),
        .note_length     (note_length),
        .is_last         (is_last),
        .done            (done),
        .key_valid       (key_valid),
        .key_root        (key_root),
        .key_minor       (key_minor),
        .key_correlation (key_correlation)
    );

    musical_key_estimator_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .note_pitch_q8   (note_pitch_q8),
        .note_length     (note_length),
        .is_last         (is_last),
        .done            (done),
        .key_valid       (key_valid),
        .key_root        (key_root),
        .key_minor       (key_minor),
        .key_correlation (key_correlation),
        .mismatches      (mismatches),
        .awaiting        (awaiting)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // offer one note from a falling edge and hold it until busy is low at a
    // rising edge; random idle cycles go ahead of the note, except in a stretch
    // in the middle of the run where notes follow back to back
    task automatic send_note(input logic [PITCH_W-1:0] pitch,
                             input logic [LEN_W-1:0] len,
                             input logic last);
        while ((notes_sent < 500 || notes_sent >= 800) && $urandom_range(99) < 7) begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        note_pitch_q8 = pitch;
        note_length = len;
        is_last = last;
        forever begin
            @(posedge clk);
            if (!busy)
                break;
        end
        notes_sent++;
        @(negedge clk);
        start = 1'b0;
    endtask

    // random length: zeros, small weights, full scale and anything between
    function automatic logic [LEN_W-1:0] pick_length();
        int sel;
        sel = $urandom_range(99);
        if (sel < 8)
            return '0;
        if (sel < 30)
            return LEN_W'($urandom_range(1, 40));
        if (sel < 40)
            return '1;
        return LEN_W'($urandom);
    endfunction

    initial begin
        int n;
        bit silent;
        start = 1'b0;
        note_pitch_q8 = '0;
        note_length = '0;
        is_last = 1'b0;
        notes_sent = 0;
        rst_n = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // zero total weight gives an invalid key
        send_note('0, '0, 1'b1);
        // extreme pitch and length as a one-note set
        send_note('1, '1, 1'b1);
        // a zero-length note inside a set, then a real note
        send_note(15'd1000, '0, 1'b0);
        send_note(15'd1000, 16'd7, 1'b1);
        // rounding edge: 127 stays on c, 128 rounds up to c sharp
        send_note(15'd127, 16'd300, 1'b0);
        send_note(15'd128, 16'd300, 1'b1);
        // flat histogram: equal weight on every class
        for (int i = 0; i < NUM_CLASSES; i++)
            send_note(PITCH_W'(i * 256 + 3072), 16'd100, i == NUM_CLASSES - 1);
        // c major triad weighted toward the tonic
        send_note(15'd15360, 16'd900, 1'b0);
        send_note(15'd16384, 16'd500, 1'b0);
        send_note(15'd17152, 16'd600, 1'b1);

        // random sets, mostly short, a few long ones to push the sums up
        while (notes_sent < 1250) begin
            n = ($urandom_range(99) < 10) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            silent = ($urandom_range(99) < 4);
            for (int i = 0; i < n; i++)
                send_note(PITCH_W'($urandom), silent ? '0 : pick_length(), i == n - 1);
        end

        wait (awaiting == 0);
        repeat (1300) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
